// ----- rtl/vdc_pkg.sv -----
// ----------------------------------------------------------------------------
// vdc_pkg: shared types and constants for the direction cosine pipeline
// Component width, derived field widths, beat payload structs and the
// per-stage state carried down the bit-recurrence pipeline.
// ----------------------------------------------------------------------------
package vdc_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int COS_WIDTH  = 16;
    localparam int MAG_WIDTH  = 16;
    localparam int NUM_COMP   = 3;

    // sum of squares, root, root squared, q*s, q^2*s
    localparam int WS   = 2 * COMP_WIDTH;
    localparam int WR   = COMP_WIDTH;
    localparam int WR2  = 2 * COMP_WIDTH + 2;
    localparam int WQS  = 2 * COMP_WIDTH + COS_WIDTH;
    localparam int WP   = 2 * COMP_WIDTH + 34;
    localparam int NSTG = (COMP_WIDTH > COS_WIDTH) ? COMP_WIDTH : COS_WIDTH;
    localparam int RHS_SHIFT = 30;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] comp_x;
        logic signed [COMP_WIDTH-1:0] comp_y;
        logic signed [COMP_WIDTH-1:0] comp_z;
    } t_vec_in;

    typedef struct packed {
        logic [MAG_WIDTH-1:0]        magnitude;
        logic signed [COS_WIDTH-1:0] cos_x;
        logic signed [COS_WIDTH-1:0] cos_y;
        logic signed [COS_WIDTH-1:0] cos_z;
        logic                        zero_vector;
    } t_vec_out;

    typedef struct packed {
        logic [NUM_COMP-1:0]                neg;
        logic [NUM_COMP-1:0][WS-1:0]        sq;
    } t_sq;

    typedef struct packed {
        logic [WS-1:0]                      s;
        logic                               zero;
        logic [NUM_COMP-1:0]                neg;
        logic [NUM_COMP-1:0][WP-1:0]        rhs;
        logic [WR-1:0]                      root;
        logic [WR2-1:0]                     root_sq;
        logic [NUM_COMP-1:0][COS_WIDTH-1:0] q;
        logic [NUM_COMP-1:0][WP-1:0]        p;
        logic [NUM_COMP-1:0][WQS-1:0]       qs;
    } t_stage;

endpackage

// ----- rtl/vector_direction_cosines.sv -----
// ----------------------------------------------------------------------------
// vector_direction_cosines: magnitude and Q1.15 direction cosines
// Beats pass the squares, seed, NSTG bit-stage and output registers in turn.
// Throughput: one vector per cycle unless the output stalls; the root and the
// three cosines are resolved one bit per pipeline stage, all stages advancing
// together. A stalled output beat freezes the whole pipeline; nothing is dropped.
// Reset (synchronous, active low) clears all stage valid bits only.
// ----------------------------------------------------------------------------
module vector_direction_cosines (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vdc_pkg::t_vec_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vdc_pkg::t_vec_out   o_out_data
);

    localparam int W    = vdc_pkg::COMP_WIDTH;
    localparam int NC   = vdc_pkg::NUM_COMP;
    localparam int NSTG = vdc_pkg::NSTG;
    localparam int QW   = vdc_pkg::COS_WIDTH;
    localparam logic [QW:0] Q_ONE = (QW + 1)'(1) << (QW - 1);

    logic w_adv;

    logic                r_v0;
    vdc_pkg::t_sq        r_sq, n_sq;
    logic                r_v1;
    vdc_pkg::t_stage     r_init, n_init;
    logic [NSTG-1:0]     r_vstg;
    vdc_pkg::t_stage     r_stg [NSTG];
    vdc_pkg::t_stage     n_stg [NSTG];
    vdc_pkg::t_stage     w_sin [NSTG];
    logic                r_vout;
    vdc_pkg::t_vec_out   r_out, n_out;

    // the whole pipe moves unless the output beat is held
    assign w_adv       = !r_vout || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vout;
    assign o_out_data  = r_out;

    // stage 0: absolute values and squares
    always_comb begin
        logic [NC-1:0][W-1:0] comp;
        logic [W-1:0]         a;
        comp = {i_in_data.comp_x, i_in_data.comp_y, i_in_data.comp_z};
        for (int c = 0; c < NC; c++) begin
            n_sq.neg[NC-1-c] = comp[c][W-1];
            a = comp[c][W-1] ? (~comp[c] + W'(1)) : comp[c];
            n_sq.sq[NC-1-c] = vdc_pkg::WS'(a) * vdc_pkg::WS'(a);
        end
    end

    // stage 1: sum of squares and recurrence seeds
    always_comb begin
        n_init = '0;
        n_init.s = r_sq.sq[0] + r_sq.sq[1] + r_sq.sq[2];
        n_init.zero = (n_init.s == '0);
        n_init.neg = r_sq.neg;
        for (int c = 0; c < NC; c++) begin
            n_init.rhs[c] = vdc_pkg::WP'(r_sq.sq[c]) << vdc_pkg::RHS_SHIFT;
        end
    end

    assign w_sin[0] = r_init;

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam int B = NSTG - 1 - k;
        if (k > 0) begin : g_link
            assign w_sin[k] = r_stg[k-1];
        end

        // one bit of root and of each cosine: try the bit, keep it if it fits
        always_comb begin
            logic [vdc_pkg::WR2-1:0] rc;
            logic [vdc_pkg::WP-1:0]  pc;
            n_stg[k] = w_sin[k];
            if (B < vdc_pkg::WR) begin
                rc = w_sin[k].root_sq
                   + (vdc_pkg::WR2'(w_sin[k].root) << (B + 1))
                   + (vdc_pkg::WR2'(1) << (2 * B));
                if (rc <= vdc_pkg::WR2'(w_sin[k].s)) begin
                    n_stg[k].root    = w_sin[k].root | (vdc_pkg::WR'(1) << B);
                    n_stg[k].root_sq = rc;
                end
            end
            if (B < QW) begin
                for (int c = 0; c < NC; c++) begin
                    pc = w_sin[k].p[c]
                       + (vdc_pkg::WP'(w_sin[k].qs[c]) << (B + 1))
                       + (vdc_pkg::WP'(w_sin[k].s) << (2 * B));
                    if (pc <= w_sin[k].rhs[c]) begin
                        n_stg[k].q[c]  = w_sin[k].q[c] | (QW'(1) << B);
                        n_stg[k].p[c]  = pc;
                        n_stg[k].qs[c] = w_sin[k].qs[c]
                                       + (vdc_pkg::WQS'(w_sin[k].s) << B);
                    end
                end
            end
        end
    end

    // output formatting: saturate magnitude, sign and clamp cosines
    always_comb begin
        logic [NC-1:0][QW-1:0] cs;
        logic [QW:0]           qc;
        vdc_pkg::t_stage       f;
        f = r_stg[NSTG-1];
        for (int c = 0; c < NC; c++) begin
            qc = ({1'b0, f.q[c]} > Q_ONE) ? Q_ONE : {1'b0, f.q[c]};
            if (f.zero) begin
                cs[c] = '0;
            end else if (f.neg[c]) begin
                cs[c] = QW'(~qc + 1'b1);
            end else if (qc >= Q_ONE) begin
                cs[c] = QW'(Q_ONE - 1'b1);
            end else begin
                cs[c] = QW'(qc);
            end
        end
        n_out.magnitude   = (33'(f.root) > 33'h0FFFF) ? 16'hFFFF
                                                      : vdc_pkg::MAG_WIDTH'(f.root);
        n_out.cos_x       = cs[0];
        n_out.cos_y       = cs[1];
        n_out.cos_z       = cs[2];
        n_out.zero_vector = f.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_vstg <= '0;
            r_vout <= 1'b0;
        end else if (w_adv) begin
            r_v0   <= i_in_valid;
            r_v1   <= r_v0;
            r_vstg <= {r_vstg[NSTG-2:0], r_v1};
            r_vout <= r_vstg[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq   <= n_sq;
            r_init <= n_init;
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_out  <= n_out;
        end
    end

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v0)
        else $error("accepted beat did not enter the pipeline");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_vector |->
            o_out_data.magnitude == '0 && o_out_data.cos_x == '0 &&
            o_out_data.cos_y == '0 && o_out_data.cos_z == '0)
        else $error("zero vector beat carries non-zero fields");

    a_nonzero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.zero_vector |-> o_out_data.magnitude != '0)
        else $error("non-zero vector produced zero magnitude");

endmodule

// ----- sim/tb_vector_direction_cosines.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_direction_cosines: regression for the direction cosine pipeline
// Drives vectors in bursts, stalls the output side on its own pattern, and
// checks every output beat against expected magnitude and Q1.15 cosines, from a
// directed table or a bit-exact integer model, held in an in-order list.
// ----------------------------------------------------------------------------
module tb_vector_direction_cosines;

    localparam int N_DIRECTED = 16;
    localparam int N_RANDOM   = 1200;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    vdc_pkg::t_vec_in  i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    vdc_pkg::t_vec_out o_out_data;

    vdc_pkg::t_vec_out exp_mem[N_DIRECTED + N_RANDOM];
    int       n_sent;
    int       n_checked;
    int       n_errors;
    int       n_cycles;
    bit       stim_done;
    bit       hold_off;

    typedef struct {
        vdc_pkg::t_vec_in  vec;
        bit                known;
        vdc_pkg::t_vec_out res;
    } t_row;
    t_row vec_table[N_DIRECTED];

    vector_direction_cosines u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // floor(32768 * a / sqrt(s)) via the largest q with q*q*s <= a*a*2^30
    function automatic logic [15:0] q15_cosine(logic [15:0] a, bit neg, logic [33:0] s);
        logic [63:0]  rhs;
        logic [16:0]  q;
        logic [16:0]  t;
        logic [127:0] lhs;
        rhs = 64'(a) * 64'(a) << 30;
        q = '0;
        for (int b = 15; b >= 0; b--) begin
            t = q | (17'd1 << b);
            lhs = 128'(t) * 128'(t) * 128'(s);
            if (lhs <= 128'(rhs)) q = t;
        end
        if (neg) return 16'(17'h10000 - q);
        if (q >= 17'd32768) q = 17'd32767;
        return q[15:0];
    endfunction

    function automatic vdc_pkg::t_vec_out direction_cosines(vdc_pkg::t_vec_in v);
        vdc_pkg::t_vec_out r;
        logic [15:0] ax, ay, az;
        logic [33:0] s;
        logic [33:0] root;
        logic [33:0] t;
        ax = v.comp_x[15] ? 16'(-v.comp_x) : v.comp_x;
        ay = v.comp_y[15] ? 16'(-v.comp_y) : v.comp_y;
        az = v.comp_z[15] ? 16'(-v.comp_z) : v.comp_z;
        s = 34'(ax) * ax + 34'(ay) * ay + 34'(az) * az;
        r = '0;
        if (s == 0) begin
            r.zero_vector = 1'b1;
            return r;
        end
        root = '0;
        for (int b = 16; b >= 0; b--) begin
            t = root | (34'd1 << b);
            if (68'(t) * t <= 68'(s)) root = t;
        end
        r.magnitude = (root > 34'hFFFF) ? 16'hFFFF : root[15:0];
        r.cos_x = q15_cosine(ax, v.comp_x[15], s);
        r.cos_y = q15_cosine(ay, v.comp_y[15], s);
        r.cos_z = q15_cosine(az, v.comp_z[15], s);
        return r;
    endfunction

    function automatic vdc_pkg::t_vec_in vec3(int x, int y, int z);
        vdc_pkg::t_vec_in v;
        v.comp_x = 16'(x);
        v.comp_y = 16'(y);
        v.comp_z = 16'(z);
        return v;
    endfunction

    function automatic vdc_pkg::t_vec_out res5(int m, int cx, int cy, int cz, bit zv);
        vdc_pkg::t_vec_out r;
        r.magnitude   = 16'(m);
        r.cos_x       = 16'(cx);
        r.cos_y       = 16'(cy);
        r.cos_z       = 16'(cz);
        r.zero_vector = zv;
        return r;
    endfunction

    function automatic vdc_pkg::t_vec_in random_vec();
        vdc_pkg::t_vec_in v;
        int               mode;
        mode = $urandom_range(0, 9);
        v = vdc_pkg::t_vec_in'({$urandom, $urandom});
        case (mode)
            0: v = vec3($urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
                        $urandom_range(0, 15) - 8);
            1: v.comp_z = '0;
            2: begin
                v.comp_y = '0;
                v.comp_z = '0;
            end
            3: v.comp_x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        vec_table[0]  = '{vec3(0, 0, 0), 1, res5(0, 0, 0, 0, 1)};
        vec_table[1]  = '{vec3(1, 0, 0), 1, res5(1, 32767, 0, 0, 0)};
        vec_table[2]  = '{vec3(-1, 0, 0), 1, res5(1, -32768, 0, 0, 0)};
        vec_table[3]  = '{vec3(0, 32767, 0), 1, res5(32767, 0, 32767, 0, 0)};
        vec_table[4]  = '{vec3(0, 0, -32768), 1, res5(32768, 0, 0, -32768, 0)};
        vec_table[5]  = '{vec3(3, 4, 0), 1, res5(5, 19660, 26214, 0, 0)};
        vec_table[6]  = '{vec3(-3, 0, -4), 1, res5(5, -19660, 0, -26214, 0)};
        vec_table[7]  = '{vec3(2, 3, 6), 1, res5(7, 9362, 14043, 28086, 0)};
        vec_table[8]  = '{vec3(-32768, -32768, -32768), 0, '0};
        vec_table[9]  = '{vec3(32767, 32767, 32767), 0, '0};
        vec_table[10] = '{vec3(-32768, 32767, 0), 0, '0};
        vec_table[11] = '{vec3(1, 1, 1), 0, '0};
        vec_table[12] = '{vec3(1, -1, 0), 0, '0};
        vec_table[13] = '{vec3(21845, -10922, 5461), 0, '0};
        vec_table[14] = '{vec3(-1, -1, -1), 0, '0};
        vec_table[15] = '{vec3(0, 0, 0), 1, res5(0, 0, 0, 0, 1)};
    end

    task automatic send_vector(vdc_pkg::t_vec_in v, bit known, vdc_pkg::t_vec_out res);
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        exp_mem[n_sent] = known ? res : direction_cosines(v);
        n_sent++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // sender: bursts with random gaps
    initial begin
        int burst;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        n_errors   = 0;
        n_sent     = 0;
        n_checked  = 0;
        stim_done  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (vec_table[k])
            send_vector(vec_table[k].vec, vec_table[k].known, vec_table[k].res);
        burst = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            burst--;
            send_vector(random_vec(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // long hold-off once, early in the random part
    initial begin
        hold_off = 1'b0;
        repeat (120) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // receiver: stall pattern of its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off) begin
            i_out_ready <= 1'b0;
        end else if (n_cycles % 700 < 150) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        vdc_pkg::t_vec_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (n_checked >= n_sent) begin
                $display("%0t: unexpected beat %p", $time, o_out_data);
                n_errors++;
            end else begin
                want = exp_mem[n_checked];
                n_checked++;
                if (want.magnitude !== o_out_data.magnitude) begin
                    $display("%0t: magnitude exp %0d got %0d", $time,
                             want.magnitude, o_out_data.magnitude);
                    n_errors++;
                end
                if (want.cos_x !== o_out_data.cos_x) begin
                    $display("%0t: cos_x exp %0d got %0d", $time, want.cos_x,
                             o_out_data.cos_x);
                    n_errors++;
                end
                if (want.cos_y !== o_out_data.cos_y) begin
                    $display("%0t: cos_y exp %0d got %0d", $time, want.cos_y,
                             o_out_data.cos_y);
                    n_errors++;
                end
                if (want.cos_z !== o_out_data.cos_z) begin
                    $display("%0t: cos_z exp %0d got %0d", $time, want.cos_z,
                             o_out_data.cos_z);
                    n_errors++;
                end
                if (want.zero_vector !== o_out_data.zero_vector) begin
                    $display("%0t: zero_vector exp %0b got %0b", $time,
                             want.zero_vector, o_out_data.zero_vector);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        n_cycles = 0;
        forever begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles >= CYCLE_LIMIT) begin
                $display("vector_direction_cosines regression: fail");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        while (n_checked != n_sent) @(posedge i_clk);
        repeat (3 * (vdc_pkg::NSTG + 3)) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("vector_direction_cosines regression: pass");
        end else begin
            $display("vector_direction_cosines regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/vdc_pkg.sv
rtl/vector_direction_cosines.sv
sim/tb_vector_direction_cosines.sv
